// ----- hw/rtl/bfb_pkg.sv -----
// ----------------------------------------------------------------------------
// bfb_pkg
// Shared types, register indexes and helpers for the BMP to framebuffer blit.
// ----------------------------------------------------------------------------
package bfb_pkg;

   localparam int MAX_DIM = 2048;
   localparam int DIM_W   = 12;                 // width of a dimension register
   localparam int ORG_W   = 11;                 // width of an origin register
   localparam int COUNT_W = $clog2(MAX_DIM);    // column and row counters
   localparam int ADDR_W  = 22;
   localparam int ARGB_W  = 24;
   localparam int IDX_W   = 3;
   localparam int CSR_W   = 12;

   localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
   localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
   localparam logic [IDX_W-1:0] REG_X_ORIGIN      = 3'd2;
   localparam logic [IDX_W-1:0] REG_Y_ORIGIN      = 3'd3;
   localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
   localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;

   localparam logic [1:0] PHASE_BLUE  = 2'd0;
   localparam logic [1:0] PHASE_GREEN = 2'd1;
   localparam logic [1:0] PHASE_RED   = 2'd2;

   typedef struct packed {
      logic [DIM_W-1:0] width_eff;
      logic [DIM_W-1:0] height_eff;
      logic [ORG_W-1:0] x_origin;
      logic [ORG_W-1:0] y_origin;
      logic [DIM_W-1:0] screen_width;
      logic [DIM_W-1:0] screen_height;
   } cfg_type;

   typedef struct packed {
      logic [DIM_W-1:0]  xs;
      logic [DIM_W-1:0]  ys;
      logic [ARGB_W-1:0] argb;
      logic              write_enable;
      logic              image_end;
   } pix_type;

   // Zero acts as one, anything above the maximum acts as the maximum.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/bfb_if.sv -----
// ----------------------------------------------------------------------------
// bfb interfaces
// Valid/ready channels for the byte input, the pixel result and the CSR port.
// ----------------------------------------------------------------------------
interface bfb_req_if import bfb_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface bfb_rsp_if import bfb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] pixel_address;
   logic [ARGB_W-1:0] pixel_argb;
   logic              write_enable;
   logic              image_end;
   modport source (output valid, output pixel_address, output pixel_argb,
                   output write_enable, output image_end, input ready);
   modport sink   (input valid, input pixel_address, input pixel_argb,
                   input write_enable, input image_end, output ready);
endinterface

interface bfb_csr_if import bfb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [CSR_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/bfb_csr.sv -----
// ----------------------------------------------------------------------------
// bfb_csr
// Configuration registers, with the image dimensions clamped to legal range.
// ----------------------------------------------------------------------------
module bfb_csr import bfb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bfb_csr_if.sink     csr_ch,
   output cfg_type     cfg
);

   logic [DIM_W-1:0] image_width_ff,   image_width_in;
   logic [DIM_W-1:0] image_height_ff,  image_height_in;
   logic [ORG_W-1:0] x_origin_ff,      x_origin_in;
   logic [ORG_W-1:0] y_origin_ff,      y_origin_in;
   logic [DIM_W-1:0] screen_width_ff,  screen_width_in;
   logic [DIM_W-1:0] screen_height_ff, screen_height_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      image_width_in   = image_width_ff;
      image_height_in  = image_height_ff;
      x_origin_in      = x_origin_ff;
      y_origin_in      = y_origin_ff;
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_IMAGE_WIDTH:   image_width_in   = csr_ch.data;
            REG_IMAGE_HEIGHT:  image_height_in  = csr_ch.data;
            REG_X_ORIGIN:      x_origin_in      = csr_ch.data[ORG_W-1:0];
            REG_Y_ORIGIN:      y_origin_in      = csr_ch.data[ORG_W-1:0];
            REG_SCREEN_WIDTH:  screen_width_in  = csr_ch.data;
            REG_SCREEN_HEIGHT: screen_height_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= DIM_W'(800);
         image_height_ff  <= DIM_W'(480);
         x_origin_ff      <= '0;
         y_origin_ff      <= '0;
         screen_width_ff  <= DIM_W'(800);
         screen_height_ff <= DIM_W'(480);
      end else begin
         image_width_ff   <= image_width_in;
         image_height_ff  <= image_height_in;
         x_origin_ff      <= x_origin_in;
         y_origin_ff      <= y_origin_in;
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
      end
   end

   assign cfg.width_eff     = eff_dim(image_width_ff);
   assign cfg.height_eff    = eff_dim(image_height_ff);
   assign cfg.x_origin      = x_origin_ff;
   assign cfg.y_origin      = y_origin_ff;
   assign cfg.screen_width  = screen_width_ff;
   assign cfg.screen_height = screen_height_ff;

endmodule

// ----- hw/rtl/bfb_parse.sv -----
// ----------------------------------------------------------------------------
// bfb_parse
// Byte sequencer: gathers pixel triples, skips row padding, tracks column and
// file row, and registers screen coordinates, color and clip for each pixel.
// ----------------------------------------------------------------------------
module bfb_parse import bfb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bfb_req_if.sink     req_ch,
   input  cfg_type     cfg,
   input  logic        pix_ready,
   output logic        pix_valid,
   output pix_type     pix
);

   logic [1:0]         byte_phase_ff, byte_phase_in;
   logic [15:0]        held_bg_ff,    held_bg_in;
   logic [COUNT_W-1:0] column_ff,     column_in;
   logic [COUNT_W-1:0] row_ff,        row_in;
   logic [1:0]         padding_ff,    padding_in;
   logic               pix_valid_ff,  pix_valid_in;
   pix_type            pix_ff,        pix_in;

   logic               accept;
   logic               emit;
   logic               last_col;
   logic               last_row;
   logic [COUNT_W-1:0] row_next;
   logic [COUNT_W-1:0] y_bmp;

   assign req_ch.ready = !pix_valid_ff || pix_ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign emit         = accept && (padding_ff == '0) && (byte_phase_ff == PHASE_RED);

   assign last_col = (DIM_W'(column_ff) + DIM_W'(1)) >= cfg.width_eff;
   assign last_row = (DIM_W'(row_ff) + DIM_W'(1)) >= cfg.height_eff;
   assign row_next = last_row ? '0 : row_ff + COUNT_W'(1);
   // A file row past a shrunken height maps to the top row.
   assign y_bmp    = (DIM_W'(row_ff) < cfg.height_eff)
                   ? COUNT_W'(cfg.height_eff - DIM_W'(1) - DIM_W'(row_ff)) : '0;

   always_comb begin
      byte_phase_in = byte_phase_ff;
      held_bg_in    = held_bg_ff;
      column_in     = column_ff;
      row_in        = row_ff;
      padding_in    = padding_ff;
      if (accept) begin
         if (padding_ff != '0) begin
            padding_in = padding_ff - 2'd1;
            if (padding_ff == 2'd1) begin
               row_in = row_next;
            end
         end else begin
            case (byte_phase_ff)
               PHASE_BLUE: begin
                  held_bg_in[7:0] = req_ch.data_byte;
                  byte_phase_in   = PHASE_GREEN;
               end
               PHASE_GREEN: begin
                  held_bg_in[15:8] = req_ch.data_byte;
                  byte_phase_in    = PHASE_RED;
               end
               default: begin
                  byte_phase_in = PHASE_BLUE;
                  if (last_col) begin
                     column_in  = '0;
                     padding_in = cfg.width_eff[1:0];
                     if (cfg.width_eff[1:0] == 2'd0) begin
                        row_in = row_next;
                     end
                  end else begin
                     column_in = column_ff + COUNT_W'(1);
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      pix_in              = pix_ff;
      pix_in.xs           = DIM_W'(cfg.x_origin) + DIM_W'(column_ff);
      pix_in.ys           = DIM_W'(cfg.y_origin) + DIM_W'(y_bmp);
      pix_in.argb         = {req_ch.data_byte, held_bg_ff};
      pix_in.write_enable = (pix_in.xs < cfg.screen_width) && (pix_in.ys < cfg.screen_height);
      pix_in.image_end    = last_col && last_row;
   end

   always_comb begin
      pix_valid_in = pix_valid_ff;
      if (emit) begin
         pix_valid_in = 1'b1;
      end else if (pix_ready) begin
         pix_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_phase_ff <= PHASE_BLUE;
         held_bg_ff    <= '0;
         column_ff     <= '0;
         row_ff        <= '0;
         padding_ff    <= '0;
         pix_valid_ff  <= 1'b0;
      end else begin
         byte_phase_ff <= byte_phase_in;
         held_bg_ff    <= held_bg_in;
         column_ff     <= column_in;
         row_ff        <= row_in;
         padding_ff    <= padding_in;
         pix_valid_ff  <= pix_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         pix_ff <= pix_in;
      end
   end

   assign pix_valid = pix_valid_ff;
   assign pix       = pix_ff;

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      byte_phase_ff != 2'd3)
      else $error("byte phase left the pixel triple");

   a_pad_at_triple_start: assert property (@(posedge clock) disable iff (reset)
      (padding_ff != '0) |-> (byte_phase_ff == PHASE_BLUE))
      else $error("padding counted in the middle of a pixel");

   a_emit_loads_stage: assert property (@(posedge clock) disable iff (reset)
      emit |=> pix_valid_ff)
      else $error("completed pixel not held in stage register");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (pix_valid_ff && !pix_ready) |-> !req_ch.ready)
      else $error("input taken while pixel stage is stalled");

endmodule

// ----- hw/rtl/bfb_addr.sv -----
// ----------------------------------------------------------------------------
// bfb_addr
// Framebuffer address stage: stride multiply plus column, into the result
// register that drives the response channel.
// ----------------------------------------------------------------------------
module bfb_addr import bfb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        pix_valid,
   input  pix_type     pix,
   output logic        pix_ready,
   bfb_rsp_if.source   rsp_ch
);

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]      addr_ff;
   logic [ARGB_W-1:0]      argb_ff;
   logic                   we_ff;
   logic                   end_ff;
   logic [2*DIM_W-1:0]     product;
   logic [2*DIM_W-1:0]     sum;
   logic                   load;

   assign pix_ready = !rsp_valid_ff || rsp_ch.ready;
   assign load      = pix_ready && pix_valid;

   // Address wraps to the framebuffer index width.
   assign product = (2*DIM_W)'(cfg.screen_width) * (2*DIM_W)'(pix.ys);
   assign sum     = product + (2*DIM_W)'(pix.xs);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pix_ready) begin
         rsp_valid_in = pix_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         addr_ff <= sum[ADDR_W-1:0];
         argb_ff <= pix.argb;
         we_ff   <= pix.write_enable;
         end_ff  <= pix.image_end;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.pixel_address = addr_ff;
   assign rsp_ch.pixel_argb    = argb_ff;
   assign rsp_ch.write_enable  = we_ff;
   assign rsp_ch.image_end     = end_ff;

endmodule

// ----- hw/rtl/bmp_to_framebuffer_blit.sv -----
// ----------------------------------------------------------------------------
// bmp_to_framebuffer_blit
// 24-bit BMP pixel stream to framebuffer writes with row flip and clipping.
// ----------------------------------------------------------------------------
// Takes one pixel-data byte per cycle (header removed, rows bottom-up, blue,
// green, red, rows padded to four bytes) and gives one framebuffer write per
// completed pixel: word address, zero-alpha ARGB, a clip enable and an
// end-of-image flag. Padding bytes give nothing. A byte is taken every cycle
// the response side is not backed up. The coordinate register takes a pixel
// when its red byte is transferred, and the stride multiply register takes it
// from there once the response side has room; that register drives the
// response channel. Write the CSRs only while no pixel is in flight.
module bmp_to_framebuffer_blit import bfb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bfb_req_if.sink     req_ch,
   bfb_rsp_if.source   rsp_ch,
   bfb_csr_if.sink     csr_ch
);

   cfg_type cfg;
   pix_type pix;
   logic    pix_valid;
   logic    pix_ready;

   bfb_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   bfb_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cfg       (cfg),
      .pix_ready (pix_ready),
      .pix_valid (pix_valid),
      .pix       (pix)
   );

   bfb_addr u_addr (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pix_valid (pix_valid),
      .pix       (pix),
      .pix_ready (pix_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the BMP to framebuffer blit. A short table of
// directed bytes and register writes is followed by random image phases;
// each pixel write is predicted from a model of the byte counters or taken
// from the table, and compared, field by field, with what the block emits.
// ----------------------------------------------------------------------------
module tb_top;
   import bfb_pkg::*;

   localparam int CYCLE_LIMIT        = 400000;
   localparam int PIPE_SETTLE_CYCLES = 8;
   localparam int RANDOM_BYTES       = 1500;
   localparam int RANDOM_PIXELS      = 60;
   localparam int PHASE_BYTE_CAP     = 900;

   // Indexes past the last register; writes to them must be ignored.
   localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [ARGB_W-1:0] argb;
      logic              write_enable;
      logic              image_end;
   } pixel_write_type;

   typedef enum {ROW_BYTE, ROW_CSR, ROW_HOLD} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic [IDX_W-1:0] index;
      logic [CSR_W-1:0] value;
      bit               typed;
      pixel_write_type  want;
   } stim_row_type;

   logic clock;
   logic reset;

   bfb_req_if req_bus ();
   bfb_rsp_if rsp_bus ();
   bfb_csr_if csr_bus ();

   bmp_to_framebuffer_blit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Blit settings as the block should hold them.
   logic [DIM_W-1:0] cfg_image_w  = 12'd800;
   logic [DIM_W-1:0] cfg_image_h  = 12'd480;
   logic [ORG_W-1:0] cfg_x_org    = '0;
   logic [ORG_W-1:0] cfg_y_org    = '0;
   logic [DIM_W-1:0] cfg_screen_w = 12'd800;
   logic [DIM_W-1:0] cfg_screen_h = 12'd480;

   // Byte-stream position as the block should track it.
   logic [1:0]  byte_phase   = PHASE_BLUE;
   logic [15:0] held_bg      = '0;
   int          column       = 0;
   int          file_row     = 0;
   int          pad_left     = 0;

   pixel_write_type pixel_writes_due [$];
   pixel_write_type oldest_due;
   int              error_count        = 0;
   int              pixels_predicted   = 0;
   int              sender_idle_pct    = 31;
   int              receiver_idle_pct  = 54;
   int              cycle_count        = 0;

   stim_row_type directed_rows [$] = '{
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h001, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h002, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h003, 1'b1, '{22'd383200, 24'h030201, 1'b1, 1'b0}},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h0ff, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h0ff, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h0ff, 1'b1, '{22'd383201, 24'hffffff, 1'b1, 1'b0}},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h000, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h000, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h000, 1'b1, '{22'd383202, 24'h000000, 1'b1, 1'b0}},
      '{ROW_HOLD, REG_IMAGE_WIDTH, 12'h000, 1'b0, '0},
      // shrink to one pixel mid-row, zero height acts as one
      '{ROW_CSR, REG_IMAGE_WIDTH, 12'h001, 1'b0, '0},
      '{ROW_CSR, REG_IMAGE_HEIGHT, 12'h000, 1'b0, '0},
      '{ROW_CSR, REG_SPARE_6, 12'hfff, 1'b0, '0},
      '{ROW_CSR, REG_SPARE_7, 12'haaa, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h05a, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h0a5, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h0c3, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h077, 1'b0, '0},
      // far origin, zero screen width, oversized image
      '{ROW_CSR, REG_X_ORIGIN, 12'hfff, 1'b0, '0},
      '{ROW_CSR, REG_Y_ORIGIN, 12'hfff, 1'b0, '0},
      '{ROW_CSR, REG_SCREEN_WIDTH, 12'h000, 1'b0, '0},
      '{ROW_CSR, REG_SCREEN_HEIGHT, 12'hfff, 1'b0, '0},
      '{ROW_CSR, REG_IMAGE_WIDTH, 12'hfff, 1'b0, '0},
      '{ROW_CSR, REG_IMAGE_HEIGHT, 12'h800, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h03c, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h0c3, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h081, 1'b0, '0},
      // widest stride: address wraps past 22 bits
      '{ROW_CSR, REG_SCREEN_WIDTH, 12'hfff, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h012, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h034, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h056, 1'b0, '0},
      // width a multiple of four: row advances with no padding
      '{ROW_CSR, REG_IMAGE_WIDTH, 12'h004, 1'b0, '0},
      '{ROW_CSR, REG_IMAGE_HEIGHT, 12'h002, 1'b0, '0},
      '{ROW_CSR, REG_X_ORIGIN, 12'h000, 1'b0, '0},
      '{ROW_CSR, REG_Y_ORIGIN, 12'h000, 1'b0, '0},
      '{ROW_CSR, REG_SCREEN_WIDTH, 12'h320, 1'b0, '0},
      '{ROW_CSR, REG_SCREEN_HEIGHT, 12'h1e0, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h080, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h001, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h0fe, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h07f, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h040, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h008, 1'b0, '0},
      // shrink height below the current file row: maps to the top row
      '{ROW_CSR, REG_IMAGE_HEIGHT, 12'h001, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h099, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h066, 1'b0, '0},
      '{ROW_BYTE, REG_IMAGE_WIDTH, 12'h033, 1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int effective_size(input logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   function automatic int next_file_row(input int row, input int height);
      return (row + 1 >= height) ? 0 : row + 1;
   endfunction

   // Advance the byte counters by one transfer; report the pixel it completes.
   task automatic model_byte(input logic [7:0] value, output bit got,
                             output pixel_write_type p);
      int w;
      int h;
      int y;
      int xs;
      int ys;
      got = 1'b0;
      p   = '0;
      w   = effective_size(cfg_image_w);
      h   = effective_size(cfg_image_h);
      if (pad_left != 0) begin
         pad_left--;
         if (pad_left == 0) file_row = next_file_row(file_row, h);
      end else if (byte_phase == PHASE_BLUE) begin
         held_bg    = {8'h00, value};
         byte_phase = PHASE_GREEN;
      end else if (byte_phase == PHASE_GREEN) begin
         held_bg[15:8] = value;
         byte_phase    = PHASE_RED;
      end else begin
         byte_phase     = PHASE_BLUE;
         y              = (file_row < h) ? h - 1 - file_row : 0;
         xs             = int'(cfg_x_org) + column;
         ys             = int'(cfg_y_org) + y;
         got            = 1'b1;
         p.argb         = {value, held_bg};
         p.write_enable = (xs < int'(cfg_screen_w)) && (ys < int'(cfg_screen_h));
         p.address      = ADDR_W'(xs + int'(cfg_screen_w) * ys);
         p.image_end    = (column + 1 >= w) && (file_row + 1 >= h);
         if (column + 1 >= w) begin
            column   = 0;
            pad_left = w % 4;
            if (pad_left == 0) file_row = next_file_row(file_row, h);
         end else begin
            column++;
         end
      end
   endtask

   // Offer one byte, with random idle cycles ahead of it, and hold until transfer.
   task automatic push_byte(input logic [7:0] value, output bit got,
                            output pixel_write_type p);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      model_byte(value, got, p);
      if (got) pixels_predicted++;
   endtask

   // Leave csr valid high; the caller drops it after the last write of a group.
   task automatic write_reg(input logic [IDX_W-1:0] index, input logic [CSR_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (index)
         REG_IMAGE_WIDTH:   cfg_image_w  = value;
         REG_IMAGE_HEIGHT:  cfg_image_h  = value;
         REG_X_ORIGIN:      cfg_x_org    = value[ORG_W-1:0];
         REG_Y_ORIGIN:      cfg_y_org    = value[ORG_W-1:0];
         REG_SCREEN_WIDTH:  cfg_screen_w = value;
         REG_SCREEN_HEIGHT: cfg_screen_h = value;
         default: ;
      endcase
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pixel_writes_due.size() != 0) @(posedge clock);
   endtask

   // Drain, then wait out PIPE_SETTLE_CYCLES with no byte offered.
   task automatic settle();
      wait_for_results();
      repeat (PIPE_SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [DIM_W-1:0] pick_dim(input int common_hi);
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return DIM_W'($urandom_range(1, common_hi));
      if (r < 85) return DIM_W'($urandom_range(10, 40));
      if (r < 89) return '0;
      if (r < 95) return DIM_W'($urandom_range(0, 4095));
      return DIM_W'(MAX_DIM);
   endfunction

   // Bit 11 is random so the masking of the origin registers is exercised.
   function automatic logic [CSR_W-1:0] pick_origin();
      int r;
      logic [CSR_W-1:0] v;
      r = $urandom_range(0, 99);
      if (r < 70) v = CSR_W'($urandom_range(0, 15));
      else if (r < 85) v = CSR_W'(2047);
      else v = CSR_W'($urandom_range(0, 2047));
      v[CSR_W-1] = 1'($urandom_range(0, 1));
      return v;
   endfunction

   // Mostly put the screen edge near the image edge so clipping flips inside it.
   function automatic logic [DIM_W-1:0] pick_screen(input int span);
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         v = span - 2 + $urandom_range(0, 3);
         if (v < 0) v = 0;
         if (v > 4095) v = 4095;
         return DIM_W'(v);
      end
      if (r < 75) return DIM_W'(4095);
      if (r < 82) return '0;
      return DIM_W'($urandom_range(0, 4095));
   endfunction

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pixel_writes_due.size() == 0) begin
            $error("pixel write with nothing outstanding: pixel_address %0d",
                   rsp_bus.pixel_address);
            error_count++;
         end else begin
            oldest_due = pixel_writes_due.pop_front();
            if (rsp_bus.pixel_address !== oldest_due.address) begin
               $error("pixel_address: expected %0d, actual %0d",
                      oldest_due.address, rsp_bus.pixel_address);
               error_count++;
            end
            if (rsp_bus.pixel_argb !== oldest_due.argb) begin
               $error("pixel_argb: expected %06h, actual %06h",
                      oldest_due.argb, rsp_bus.pixel_argb);
               error_count++;
            end
            if (rsp_bus.write_enable !== oldest_due.write_enable) begin
               $error("write_enable: expected %0b, actual %0b",
                      oldest_due.write_enable, rsp_bus.write_enable);
               error_count++;
            end
            if (rsp_bus.image_end !== oldest_due.image_end) begin
               $error("image_end: expected %0b, actual %0b",
                      oldest_due.image_end, rsp_bus.image_end);
               error_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      bit               got;
      bit               csr_open;
      pixel_write_type  p;
      int               random_bytes;
      int               w_e;
      int               h_e;
      int               count;
      logic [CSR_W-1:0] x_val;
      logic [CSR_W-1:0] y_val;
      logic [DIM_W-1:0] w_val;
      logic [DIM_W-1:0] h_val;

      csr_open          = 1'b0;
      random_bytes      = 0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_CSR: begin
               if (!csr_open) settle();
               write_reg(directed_rows[i].index, directed_rows[i].value);
               csr_open = 1'b1;
            end
            ROW_HOLD: begin
               if (csr_open) csr_bus.valid <= 1'b0;
               csr_open = 1'b0;
               wait_for_results();
            end
            default: begin
               if (csr_open) csr_bus.valid <= 1'b0;
               csr_open = 1'b0;
               push_byte(directed_rows[i].value[7:0], got, p);
               if (directed_rows[i].typed) pixel_writes_due.push_back(directed_rows[i].want);
               else if (got) pixel_writes_due.push_back(p);
            end
         endcase
      end
      if (csr_open) csr_bus.valid <= 1'b0;

      while (random_bytes < RANDOM_BYTES || pixels_predicted < RANDOM_PIXELS) begin
         if (random_bytes < RANDOM_BYTES / 3) begin
            sender_idle_pct   = 31;
            receiver_idle_pct = 54;
         end else if (random_bytes < 2 * RANDOM_BYTES / 3) begin
            sender_idle_pct   = 54;
            receiver_idle_pct = 31;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         settle();

         w_val = pick_dim(9);
         h_val = pick_dim(6);
         x_val = pick_origin();
         y_val = pick_origin();
         w_e   = effective_size(w_val);
         h_e   = effective_size(h_val);
         write_reg(REG_IMAGE_WIDTH, w_val);
         write_reg(REG_IMAGE_HEIGHT, h_val);
         write_reg(REG_X_ORIGIN, x_val);
         write_reg(REG_Y_ORIGIN, y_val);
         write_reg(REG_SCREEN_WIDTH, pick_screen(int'(x_val[ORG_W-1:0]) + w_e));
         write_reg(REG_SCREEN_HEIGHT, pick_screen(int'(y_val[ORG_W-1:0]) + h_e));
         csr_bus.valid <= 1'b0;

         // Whole images mostly; now and then a short run that breaks alignment.
         if ($urandom_range(0, 99) < 15) begin
            count = $urandom_range(1, 40);
         end else begin
            count = (w_e * 3 + w_e % 4) * h_e * $urandom_range(1, 3);
            if (count > PHASE_BYTE_CAP) count = PHASE_BYTE_CAP;
         end

         for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 299) == 0) wait_for_results();
            push_byte(8'($urandom_range(0, 255)), got, p);
            if (got) pixel_writes_due.push_back(p);
            random_bytes++;
         end
      end

      settle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/bfb_pkg.sv
hw/rtl/bfb_if.sv
hw/rtl/bfb_csr.sv
hw/rtl/bfb_parse.sv
hw/rtl/bfb_addr.sv
hw/rtl/bmp_to_framebuffer_blit.sv
tb/tb_top.sv
